// ----- rtl/cdt_pkg.sv -----
`timescale 1ns / 1ps

package cdt_pkg;

  // Default width of the text position, the pending token start and the pending length.
  localparam int unsigned POSITION_BITS = 16;

  // Width of the start and length fields of a token on the result channel.
  localparam int unsigned FIELD_BITS = 16;

  // The result queue holds this many tokens. It must be a power of two.
  localparam int unsigned QUEUE_DEPTH    = 8;
  localparam int unsigned QUEUE_IDX_BITS = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_BITS = QUEUE_IDX_BITS + 1;

  // Token kinds as they appear on the result channel.
  typedef enum logic [3:0] {
    KIND_EOF      = 4'd0,
    KIND_IDENT    = 4'd1,
    KIND_NUMBER   = 4'd2,
    KIND_LBRACE   = 4'd3,
    KIND_RBRACE   = 4'd4,
    KIND_LPAREN   = 4'd5,
    KIND_RPAREN   = 4'd6,
    KIND_SEMI     = 4'd7,
    KIND_COMMA    = 4'd8,
    KIND_STAR     = 4'd9,
    KIND_LBRACKET = 4'd10,
    KIND_RBRACKET = 4'd11,
    KIND_TYPEDEF  = 4'd12,
    KIND_STRUCT   = 4'd13,
    KIND_VOID     = 4'd14,
    KIND_UNKNOWN  = 4'd15
  } tok_kind_e;

  // One token as it is stored in the result queue.
  typedef struct packed {
    tok_kind_e               kind;
    logic [FIELD_BITS-1:0]   start;
    logic [FIELD_BITS-1:0]   length;
    logic                    last;
  } token_t;

  // Tokens that the scanner hands to the queue in one cycle, first in order first.
  // The second one is only valid when the first one is.
  typedef struct packed {
    logic   first_valid;
    token_t first;
    logic   second_valid;
    token_t second;
  } push_t;

endpackage

// ----- rtl/cdt_in_if.sv -----
`timescale 1ns / 1ps

// Character channel: one text byte or the end of text marker per request.
interface cdt_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] char_byte;

  modport source (output valid, output req_type, output char_byte, input ready);
  modport sink (input valid, input req_type, input char_byte, output ready);
endinterface

// ----- rtl/cdt_out_if.sv -----
`timescale 1ns / 1ps

// Token channel: one token per request.
interface cdt_out_if;
  logic                            valid;
  logic                            ready;
  logic [3:0]                      tok_kind;
  logic [cdt_pkg::FIELD_BITS-1:0]  token_start;
  logic [cdt_pkg::FIELD_BITS-1:0]  token_length;
  logic                            last_of_run;

  modport source (output valid, output tok_kind, output token_start,
                  output token_length, output last_of_run, input ready);
  modport sink (input valid, input tok_kind, input token_start,
                input token_length, input last_of_run, output ready);
endinterface

// ----- rtl/cdt_scanner.sv -----
`timescale 1ns / 1ps

module cdt_scanner #(
  parameter int unsigned POSITION_BITS = cdt_pkg::POSITION_BITS
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            item_valid_i,
  input  logic            req_type_i,
  input  logic [7:0]      char_byte_i,
  output cdt_pkg::push_t  push_o
);

  // Scan mode codes.
  localparam logic [2:0] MODE_IDLE       = 3'd0;
  localparam logic [2:0] MODE_IDENT      = 3'd1;
  localparam logic [2:0] MODE_NUMBER     = 3'd2;
  localparam logic [2:0] MODE_SLASH      = 3'd3;
  localparam logic [2:0] MODE_BLOCK      = 3'd4;
  localparam logic [2:0] MODE_BLOCK_STAR = 3'd5;
  localparam logic [2:0] MODE_LINE       = 3'd6;

  // Characters with a meaning of their own.
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_TAB        = 8'h09;
  localparam logic [7:0] CH_NEWLINE    = 8'h0A;
  localparam logic [7:0] CH_VTAB       = 8'h0B;
  localparam logic [7:0] CH_FORMFEED   = 8'h0C;
  localparam logic [7:0] CH_RETURN     = 8'h0D;
  localparam logic [7:0] CH_SLASH      = 8'h2F;
  localparam logic [7:0] CH_STAR       = 8'h2A;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_DIGIT_0    = 8'h30;
  localparam logic [7:0] CH_DIGIT_9    = 8'h39;
  localparam logic [7:0] CH_LOWER_A    = 8'h61;
  localparam logic [7:0] CH_LOWER_Z    = 8'h7A;
  localparam logic [7:0] CH_UPPER_A    = 8'h41;
  localparam logic [7:0] CH_UPPER_Z    = 8'h5A;
  localparam logic [7:0] CH_LBRACE     = 8'h7B;
  localparam logic [7:0] CH_RBRACE     = 8'h7D;
  localparam logic [7:0] CH_LPAREN     = 8'h28;
  localparam logic [7:0] CH_RPAREN     = 8'h29;
  localparam logic [7:0] CH_SEMI       = 8'h3B;
  localparam logic [7:0] CH_COMMA      = 8'h2C;
  localparam logic [7:0] CH_LBRACKET   = 8'h5B;
  localparam logic [7:0] CH_RBRACKET   = 8'h5D;

  // Keyword lengths: bit 0 typedef, bit 1 struct, bit 2 void.
  localparam int unsigned KW_LEN [3] = '{7, 6, 4};

  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
  localparam int unsigned FB = cdt_pkg::FIELD_BITS;

  logic [2:0]               mode_q, mode_d;
  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic [POSITION_BITS-1:0] start_q, start_d;
  logic [POSITION_BITS-1:0] len_q, len_d;
  logic [2:0]               kw_q, kw_d;

  logic                     is_space, is_digit, is_alpha, is_slash, is_star;
  logic                     punct_hit;
  cdt_pkg::tok_kind_e       punct_kind;
  logic                     flush_valid;
  cdt_pkg::tok_kind_e       flush_kind;
  logic [POSITION_BITS-1:0] pos_inc, len_inc;
  logic                     do_flush, do_idle;
  logic                     tok_a_v, tok_b_v;
  cdt_pkg::token_t          tok_a, tok_b;

  // Character of keyword k at index i.
  function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] i);
    logic [7:0] ch;
    case ({k, i})
      5'b00_000: ch = "t";
      5'b00_001: ch = "y";
      5'b00_010: ch = "p";
      5'b00_011: ch = "e";
      5'b00_100: ch = "d";
      5'b00_101: ch = "e";
      5'b00_110: ch = "f";
      5'b01_000: ch = "s";
      5'b01_001: ch = "t";
      5'b01_010: ch = "r";
      5'b01_011: ch = "u";
      5'b01_100: ch = "c";
      5'b01_101: ch = "t";
      5'b10_000: ch = "v";
      5'b10_001: ch = "o";
      5'b10_010: ch = "i";
      5'b10_011: ch = "d";
      default:   ch = 8'h00;
    endcase
    return ch;
  endfunction

  // Drops every keyword that the character at index len cannot continue.
  function automatic logic [2:0] kw_step(input logic [2:0] m,
                                         input logic [POSITION_BITS-1:0] len,
                                         input logic [7:0] c);
    logic [2:0] r;
    for (int k = 0; k < 3; k++) begin
      r[k] = m[k] && (len < POSITION_BITS'(KW_LEN[k])) && (kw_char(2'(k), len[2:0]) == c);
    end
    return r;
  endfunction

  // Character classes.
  always_comb begin
    is_space = (char_byte_i == CH_SPACE) || (char_byte_i == CH_TAB) ||
               (char_byte_i == CH_NEWLINE) || (char_byte_i == CH_VTAB) ||
               (char_byte_i == CH_FORMFEED) || (char_byte_i == CH_RETURN);
    is_digit = (char_byte_i >= CH_DIGIT_0) && (char_byte_i <= CH_DIGIT_9);
    is_alpha = ((char_byte_i >= CH_LOWER_A) && (char_byte_i <= CH_LOWER_Z)) ||
               ((char_byte_i >= CH_UPPER_A) && (char_byte_i <= CH_UPPER_Z)) ||
               (char_byte_i == CH_UNDERSCORE);
    is_slash = (char_byte_i == CH_SLASH);
    is_star  = (char_byte_i == CH_STAR);
    punct_hit  = 1'b1;
    punct_kind = cdt_pkg::KIND_UNKNOWN;
    unique case (char_byte_i)
      CH_LBRACE:   punct_kind = cdt_pkg::KIND_LBRACE;
      CH_RBRACE:   punct_kind = cdt_pkg::KIND_RBRACE;
      CH_LPAREN:   punct_kind = cdt_pkg::KIND_LPAREN;
      CH_RPAREN:   punct_kind = cdt_pkg::KIND_RPAREN;
      CH_SEMI:     punct_kind = cdt_pkg::KIND_SEMI;
      CH_COMMA:    punct_kind = cdt_pkg::KIND_COMMA;
      CH_STAR:     punct_kind = cdt_pkg::KIND_STAR;
      CH_LBRACKET: punct_kind = cdt_pkg::KIND_LBRACKET;
      CH_RBRACKET: punct_kind = cdt_pkg::KIND_RBRACKET;
      default:     punct_hit  = 1'b0;
    endcase
  end

  // Kind of the token being collected, were it closed now.
  always_comb begin
    flush_valid = (mode_q == MODE_IDENT) || (mode_q == MODE_NUMBER) || (mode_q == MODE_SLASH);
    flush_kind  = cdt_pkg::KIND_UNKNOWN;
    if (mode_q == MODE_NUMBER) begin
      flush_kind = cdt_pkg::KIND_NUMBER;
    end else if (mode_q == MODE_IDENT) begin
      flush_kind = cdt_pkg::KIND_IDENT;
      if (kw_q[0] && (len_q == POSITION_BITS'(KW_LEN[0]))) begin
        flush_kind = cdt_pkg::KIND_TYPEDEF;
      end
      if (kw_q[1] && (len_q == POSITION_BITS'(KW_LEN[1]))) begin
        flush_kind = cdt_pkg::KIND_STRUCT;
      end
      if (kw_q[2] && (len_q == POSITION_BITS'(KW_LEN[2]))) begin
        flush_kind = cdt_pkg::KIND_VOID;
      end
    end
  end

  // Next scan state and the tokens that this character closes.
  always_comb begin
    pos_inc  = (pos_q != POS_MAX) ? pos_q + POSITION_BITS'(1) : pos_q;
    len_inc  = (len_q != POS_MAX) ? len_q + POSITION_BITS'(1) : len_q;
    mode_d   = mode_q;
    pos_d    = pos_q;
    start_d  = start_q;
    len_d    = len_q;
    kw_d     = kw_q;
    do_flush = 1'b0;
    do_idle  = 1'b0;
    tok_b_v  = 1'b0;

    tok_b.kind   = cdt_pkg::KIND_EOF;
    tok_b.start  = FB'(pos_q);
    tok_b.length = '0;
    tok_b.last   = 1'b1;

    if (item_valid_i) begin
      pos_d = pos_inc;
      if (req_type_i) begin
        // End of text: close what is pending, report the end, start over.
        do_flush = 1'b1;
        tok_b_v  = 1'b1;
        mode_d   = MODE_IDLE;
        pos_d    = '0;
        start_d  = '0;
        len_d    = '0;
        kw_d     = '1;
      end else begin
        unique case (mode_q)
          MODE_IDENT: begin
            if (is_alpha || is_digit) begin
              kw_d  = kw_step(kw_q, len_q, char_byte_i);
              len_d = len_inc;
            end else begin
              do_flush = 1'b1;
              do_idle  = 1'b1;
            end
          end
          MODE_NUMBER: begin
            if (is_digit) begin
              len_d = len_inc;
            end else begin
              do_flush = 1'b1;
              do_idle  = 1'b1;
            end
          end
          MODE_SLASH: begin
            if (is_star) begin
              mode_d = MODE_BLOCK;
            end else if (is_slash) begin
              mode_d = MODE_LINE;
            end else begin
              do_flush = 1'b1;
              do_idle  = 1'b1;
            end
          end
          MODE_BLOCK: begin
            if (is_star) begin
              mode_d = MODE_BLOCK_STAR;
            end
          end
          MODE_BLOCK_STAR: begin
            if (is_slash) begin
              mode_d = MODE_IDLE;
            end else if (!is_star) begin
              mode_d = MODE_BLOCK;
            end
          end
          MODE_LINE: begin
            if (char_byte_i == CH_NEWLINE) begin
              mode_d = MODE_IDLE;
            end
          end
          default: begin
            do_idle = 1'b1;
          end
        endcase

        // A character seen between tokens opens a token or is one, unless it is whitespace.
        if (do_idle) begin
          mode_d       = MODE_IDLE;
          tok_b.kind   = punct_hit ? punct_kind : cdt_pkg::KIND_UNKNOWN;
          tok_b.length = FB'(1);
          if (is_slash) begin
            mode_d  = MODE_SLASH;
            start_d = pos_q;
          end else if (is_digit) begin
            mode_d  = MODE_NUMBER;
            start_d = pos_q;
            len_d   = POSITION_BITS'(1);
          end else if (is_alpha) begin
            mode_d  = MODE_IDENT;
            start_d = pos_q;
            len_d   = POSITION_BITS'(1);
            kw_d    = kw_step(3'b111, '0, char_byte_i);
          end else if (!is_space) begin
            tok_b_v = 1'b1;
          end
        end
      end
    end

    tok_a_v      = do_flush && flush_valid;
    tok_a.kind   = flush_kind;
    tok_a.start  = FB'(start_q);
    tok_a.length = (mode_q == MODE_SLASH) ? FB'(1) : FB'(len_q);
    tok_a.last   = !tok_b_v;
  end

  // Pack the tokens in order so the first slot is always filled first.
  always_comb begin
    push_o.first_valid  = tok_a_v || tok_b_v;
    push_o.first        = tok_a_v ? tok_a : tok_b;
    push_o.second_valid = tok_a_v && tok_b_v;
    push_o.second       = tok_b;
  end

  // Scan state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      pos_q   <= '0;
      start_q <= '0;
      len_q   <= '0;
      kw_q    <= '1;
    end else begin
      mode_q  <= mode_d;
      pos_q   <= pos_d;
      start_q <= start_d;
      len_q   <= len_d;
      kw_q    <= kw_d;
    end
  end

  // The end of text marker leaves the scanner as after reset.
  a_eof_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_valid_i && req_type_i |=> mode_q == MODE_IDLE && pos_q == '0 && kw_q == 3'b111)
    else $error("scanner did not restart after end of text");

  // Two tokens in one cycle: only the second one closes the run.
  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.second_valid |-> push_o.first_valid && !push_o.first.last && push_o.second.last)
    else $error("token pair out of order");

endmodule

// ----- rtl/cdt_token_queue.sv -----
`timescale 1ns / 1ps

module cdt_token_queue (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  cdt_pkg::push_t                       push_i,
  input  logic                                 pop_i,
  output cdt_pkg::token_t                      head_o,
  output logic                                 valid_o,
  output logic [cdt_pkg::QUEUE_CNT_BITS-1:0]   count_o
);

  localparam int unsigned IDX_BITS = cdt_pkg::QUEUE_IDX_BITS;
  localparam int unsigned CNT_BITS = cdt_pkg::QUEUE_CNT_BITS;

  cdt_pkg::token_t     mem_q [cdt_pkg::QUEUE_DEPTH];
  logic [IDX_BITS-1:0] head_q, head_d;
  logic [IDX_BITS-1:0] tail_q, tail_d;
  logic [IDX_BITS-1:0] tail_next;
  logic [CNT_BITS-1:0] count_q, count_d;
  logic [1:0]          n_push;
  logic                pop;

  // Pointer and fill count bookkeeping; the depth is a power of two so pointers wrap.
  always_comb begin
    n_push    = {1'b0, push_i.first_valid} + {1'b0, push_i.second_valid};
    pop       = pop_i && (count_q != '0);
    tail_next = tail_q + IDX_BITS'(1);
    tail_d    = tail_q + IDX_BITS'(n_push);
    head_d    = pop ? head_q + IDX_BITS'(1) : head_q;
    count_d   = count_q + CNT_BITS'(n_push) - CNT_BITS'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  // Token storage, up to two writes per cycle at consecutive slots.
  always_ff @(posedge clk_i) begin
    if (push_i.first_valid) begin
      mem_q[tail_q] <= push_i.first;
    end
    if (push_i.second_valid) begin
      mem_q[tail_next] <= push_i.second;
    end
  end

  assign head_o  = mem_q[head_q];
  assign valid_o = (count_q != '0);
  assign count_o = count_q;

  // The input side must never push into a full queue.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_BITS'(cdt_pkg::QUEUE_DEPTH))
    else $error("token queue overflow");

endmodule

// ----- rtl/c_declaration_tokenizer_top.sv -----
`timescale 1ns / 1ps

// Streaming tokenizer for C declaration text. Each request on in_i carries one
// text byte, or the end of text marker (req_type high), and one byte is taken
// every cycle while the token queue has room. A byte is registered on arrival,
// scanned in the next cycle, and any tokens it closes (at most two) land in an
// eight-entry token queue that drives out_o, so a token is offered on out_o once
// its closing byte has passed the input register and been written into the queue.
// out_o delivers one token per cycle while the queue is not empty; in_i drops ready
// only when the queue, counting the byte still in the input register, could not
// take two more tokens, so a text made mostly of one-character tokens runs at
// one byte per cycle as long as out_o keeps taking them. Tokens carry the
// offset of their first character and their length; last_of_run marks the last
// token that one byte produced. Whitespace and comments yield no tokens. Positions
// stop counting at their maximum. After the end of text marker the block starts
// a new text at offset zero. There is no start-up sweep after reset.
module c_declaration_tokenizer_top #(
  parameter int unsigned POSITION_BITS = cdt_pkg::POSITION_BITS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  cdt_in_if.sink           in_i,
  cdt_out_if.source        out_o
);

  localparam int unsigned CNT_BITS  = cdt_pkg::QUEUE_CNT_BITS;
  localparam int unsigned NEED_BITS = CNT_BITS + 1;

  logic                   stage_v_q;
  logic                   stage_type_q;
  logic [7:0]             stage_char_q;
  logic                   accept;
  logic [CNT_BITS-1:0]    queue_count;
  logic [NEED_BITS-1:0]   worst_fill;
  cdt_pkg::push_t         push;
  cdt_pkg::token_t        head;
  logic                   head_valid;

  // Room check: the byte in the input register and a new one may each add two tokens.
  always_comb begin
    worst_fill = NEED_BITS'(queue_count) + (stage_v_q ? NEED_BITS'(2) : '0) + NEED_BITS'(2);
  end

  assign in_i.ready = (worst_fill <= NEED_BITS'(cdt_pkg::QUEUE_DEPTH));
  assign accept     = in_i.valid && in_i.ready;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_v_q <= 1'b0;
    end else begin
      stage_v_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      stage_type_q <= in_i.req_type;
      stage_char_q <= in_i.char_byte;
    end
  end

  cdt_scanner #(
    .POSITION_BITS (POSITION_BITS)
  ) u_scanner (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (stage_v_q),
    .req_type_i   (stage_type_q),
    .char_byte_i  (stage_char_q),
    .push_o       (push)
  );

  cdt_token_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (out_o.ready),
    .head_o  (head),
    .valid_o (head_valid),
    .count_o (queue_count)
  );

  // Result channel.
  assign out_o.valid        = head_valid;
  assign out_o.tok_kind     = head.kind;
  assign out_o.token_start  = head.start;
  assign out_o.token_length = head.length;
  assign out_o.last_of_run  = head.last;

  // A byte in the input register always finds room for both of its tokens.
  a_stage_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage_v_q |-> NEED_BITS'(queue_count) + NEED_BITS'(2)
                  <= NEED_BITS'(cdt_pkg::QUEUE_DEPTH))
    else $error("input register holds a byte without queue room");

endmodule
